// File: design/pni_pkg.sv
package pni_pkg;

  // Field widths
  localparam int VALUE_W = 12;
  localparam int ADJ_W   = 6;
  localparam int NOUN_W  = 7;
  localparam int SEED_W  = 32;

  // Permutation shape
  localparam int ROUNDS   = 4;
  localparam int ROUND_W  = 2;
  localparam int XS_SHIFT = 6;
  localparam int BYTE_W   = 8;

  // Default domain split
  localparam int DEF_ADJ_COUNT  = 53;
  localparam int DEF_NOUN_COUNT = 76;

  // Reciprocal for the constant divide: q ~= (v * floor(2^S / d)) >> S
  localparam int RECIP_SHIFT = 24;

  // Odd multipliers, one per round
  localparam logic [VALUE_W-1:0] ROUND_MUL [ROUNDS] = '{
    12'h325, 12'h3f5, 12'ha89, 12'h85b
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_CHECK,
    ST_DIV_EST,
    ST_DIV_FIX,
    ST_OUT
  } pni_state_t;

  // Controller to datapath
  typedef struct packed {
    logic               load_in;
    logic               do_round;
    logic [ROUND_W-1:0] round_idx;
    logic               clear_v;
    logic               div_est;
    logic               div_fix;
    logic               load_out;
  } pni_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_domain;
  } pni_status_t;

endpackage

// File: design/pni_in_if.sv
interface pni_in_if;
  logic                        valid;
  logic                        ready;
  logic [pni_pkg::VALUE_W-1:0] sequence_number;

  modport source (output valid, output sequence_number, input ready);
  modport sink   (input valid, input sequence_number, output ready);
endinterface

// File: design/pni_out_if.sv
interface pni_out_if;
  logic                        valid;
  logic                        ready;
  logic [pni_pkg::VALUE_W-1:0] permuted_value;
  logic [pni_pkg::ADJ_W-1:0]   adjective_index;
  logic [pni_pkg::NOUN_W-1:0]  noun_index;

  modport source (output valid, output permuted_value, output adjective_index,
                  output noun_index, input ready);
  modport sink   (input valid, input permuted_value, input adjective_index,
                  input noun_index, output ready);
endinterface

// File: design/pni_cfg_if.sv
interface pni_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [pni_pkg::SEED_W-1:0] seed;

  modport source (output valid, output seed, input ready);
  modport sink   (input valid, input seed, output ready);
endinterface

// File: design/permuted_name_index.sv
// Channel   Dir  Request payload
// in_ch     in   sequence_number[11:0]
// out_ch    out  permuted_value[11:0], adjective_index[5:0], noun_index[6:0]
// cfg_ch    in   seed[31:0]
//
// Each walk pass runs four mixing rounds through one shared 12x12 multiplier, then a
// domain check; after the passes come a reciprocal estimate, a correction and the output
// load. At most 4096 passes, after which the result is all zero. Reset (rst_n low,
// synchronous) clears the seed to 0 and the controller to idle. A new request is taken
// while the previous result still waits on out_ch; the block stalls before its output
// load only if that result has not been taken. cfg_ch is always ready.
module permuted_name_index #(
  parameter int ADJ_COUNT  = pni_pkg::DEF_ADJ_COUNT,
  parameter int NOUN_COUNT = pni_pkg::DEF_NOUN_COUNT
) (
  input logic clk,
  input logic rst_n,
  pni_in_if.sink    in_ch,
  pni_out_if.source out_ch,
  pni_cfg_if.sink   cfg_ch
);
  import pni_pkg::*;

  pni_cmd_t    cmd;
  pni_status_t status;

  assign cfg_ch.ready = 1'b1;

  pni_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  pni_dp #(
    .ADJ_COUNT  (ADJ_COUNT),
    .NOUN_COUNT (NOUN_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_ch.valid && cfg_ch.ready),
    .cfg_seed        (cfg_ch.seed),
    .in_value        (in_ch.sequence_number),
    .permuted_value  (out_ch.permuted_value),
    .adjective_index (out_ch.adjective_index),
    .noun_index      (out_ch.noun_index)
  );

  // An accepted request starts at the first round
  a_start_round: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (cmd.do_round && cmd.round_idx == '0))
    else $error("request did not start at round zero");

  // Result load never overwrites an untaken result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten");

  // Remainder is reduced below the adjective count
  a_adj_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (int'(out_ch.adjective_index) < ADJ_COUNT))
    else $error("adjective index out of range");

  // Input is only taken when no work is in flight
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.do_round || cmd.div_est || cmd.div_fix) |-> !in_ch.ready)
    else $error("request accepted while busy");

endmodule

// File: design/pni_ctrl.sv
module pni_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  pni_pkg::pni_status_t status,
  output pni_pkg::pni_cmd_t    cmd
);
  import pni_pkg::*;

  pni_state_t         state_r, state_nxt;
  logic [ROUND_W-1:0] round_r, round_nxt;
  logic [VALUE_W-1:0] pass_r, pass_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_free;
  logic               last_pass;

  assign out_free  = !out_valid_r || out_ready;
  assign last_pass = (pass_r == {VALUE_W{1'b1}});

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (round_r == ROUND_W'(ROUNDS - 1)) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.in_domain || last_pass) state_nxt = ST_DIV_EST;
        else state_nxt = ST_ROUND;
      end
      ST_DIV_EST: state_nxt = ST_DIV_FIX;
      ST_DIV_FIX: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Round and walk counters
  always_comb begin
    round_nxt = round_r;
    pass_nxt  = pass_r;
    case (state_r)
      ST_IDLE: begin
        round_nxt = '0;
        pass_nxt  = '0;
      end
      ST_ROUND: round_nxt = round_r + ROUND_W'(1);
      ST_CHECK: begin
        round_nxt = '0;
        pass_nxt  = pass_r + VALUE_W'(1);
      end
      default: begin
        round_nxt = round_r;
        pass_nxt  = pass_r;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd           = '0;
    cmd.round_idx = round_r;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_ROUND:   cmd.do_round = 1'b1;
      ST_CHECK:   cmd.clear_v  = !status.in_domain && last_pass;
      ST_DIV_EST: cmd.div_est  = 1'b1;
      ST_DIV_FIX: cmd.div_fix  = 1'b1;
      ST_OUT:     cmd.load_out = out_free;
      default:    cmd          = '0;
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      round_r     <= '0;
      pass_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: design/pni_dp.sv
module pni_dp #(
  parameter int ADJ_COUNT  = pni_pkg::DEF_ADJ_COUNT,
  parameter int NOUN_COUNT = pni_pkg::DEF_NOUN_COUNT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pni_pkg::pni_cmd_t            cmd,
  output pni_pkg::pni_status_t         status,
  input  logic                         cfg_we,
  input  logic [pni_pkg::SEED_W-1:0]   cfg_seed,
  input  logic [pni_pkg::VALUE_W-1:0]  in_value,
  output logic [pni_pkg::VALUE_W-1:0]  permuted_value,
  output logic [pni_pkg::ADJ_W-1:0]    adjective_index,
  output logic [pni_pkg::NOUN_W-1:0]   noun_index
);
  import pni_pkg::*;

  localparam longint DOMAIN  = longint'(ADJ_COUNT) * longint'(NOUN_COUNT);
  localparam longint RECIP   = (64'd1 << RECIP_SHIFT) / ADJ_COUNT;
  localparam int     RECIP_W = RECIP_SHIFT + 1;
  localparam int     PROD_W  = VALUE_W + RECIP_W;
  localparam int     QD_W    = VALUE_W + 1;
  localparam int     REM_W   = ADJ_W + 1;
  localparam int     MUL_W   = 2 * VALUE_W;

  logic [SEED_W-1:0]  seed_r;
  logic [VALUE_W-1:0] v_r, v_nxt;
  logic [VALUE_W-1:0] q_r, q_nxt;
  logic [REM_W-1:0]   r_r, r_nxt;
  logic [VALUE_W-1:0] pv_r;
  logic [ADJ_W-1:0]   adj_r;
  logic [NOUN_W-1:0]  noun_r;

  logic [SEED_W-1:0]  key_sh;
  logic [VALUE_W-1:0] mixed;
  logic [MUL_W-1:0]   round_prod;
  logic [VALUE_W-1:0] round_val;
  logic [VALUE_W-1:0] round_out;
  logic [PROD_W-1:0]  recip_prod;
  logic [QD_W-1:0]    qd;
  logic [QD_W-1:0]    rem_wide;
  logic [REM_W-1:0]   rem;

  // One mixing round: xor-shift, key xor, odd multiply
  assign key_sh     = seed_r >> {cmd.round_idx, 3'b000};
  assign mixed      = v_r ^ (v_r >> XS_SHIFT) ^ key_sh[VALUE_W-1:0];
  assign round_prod = MUL_W'(mixed) * MUL_W'(ROUND_MUL[cmd.round_idx]);
  assign round_val  = round_prod[VALUE_W-1:0];
  // final xor-shift rides on the last round
  assign round_out  = (cmd.round_idx == ROUND_W'(ROUNDS - 1)) ?
                      (round_val ^ (round_val >> XS_SHIFT)) : round_val;

  // Domain check
  assign status.in_domain = (longint'(v_r) < DOMAIN);

  // Constant divide: reciprocal estimate, then one correction step
  assign recip_prod = PROD_W'(v_r) * PROD_W'(RECIP);
  assign qd         = QD_W'(q_r) * QD_W'(ADJ_COUNT);
  assign rem_wide   = QD_W'(v_r) - qd;
  assign rem        = rem_wide[REM_W-1:0];

  always_comb begin
    v_nxt = v_r;
    q_nxt = q_r;
    r_nxt = r_r;
    if (cmd.load_in) v_nxt = in_value;
    else if (cmd.do_round) v_nxt = round_out;
    else if (cmd.clear_v) v_nxt = '0;
    if (cmd.div_est) q_nxt = recip_prod[RECIP_SHIFT +: VALUE_W];
    if (cmd.div_fix) begin
      if (rem >= REM_W'(ADJ_COUNT)) begin
        q_nxt = q_r + VALUE_W'(1);
        r_nxt = rem - REM_W'(ADJ_COUNT);
      end else begin
        r_nxt = rem;
      end
    end
  end

  // Seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_we) begin
      seed_r <= cfg_seed;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    q_r <= q_nxt;
    r_r <= r_nxt;
    if (cmd.load_out) begin
      pv_r   <= v_r;
      adj_r  <= r_r[ADJ_W-1:0];
      noun_r <= q_r[NOUN_W-1:0];
    end
  end

  assign permuted_value  = pv_r;
  assign adjective_index = adj_r;
  assign noun_index      = noun_r;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pni_pkg::*;

  localparam int ADJ_COUNT       = DEF_ADJ_COUNT;
  localparam int NOUN_COUNT      = DEF_NOUN_COUNT;
  localparam int NAME_DOMAIN     = ADJ_COUNT * NOUN_COUNT;
  localparam int WALK_LIMIT      = 4096;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 92;
  localparam int SETTLE_CYCLES   = 16;
  localparam int QUIET_LIMIT     = 20000;

  localparam logic [VALUE_W-1:0] MIX_MUL [ROUNDS] = '{
    12'h325, 12'h3f5, 12'ha89, 12'h85b
  };

  // Idling patterns, one per phase in rotation
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idling_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [ADJ_W-1:0]   adj;
    logic [NOUN_W-1:0]  noun;
  } name_entry_t;

  // Predicts each name index and checks results in request order
  class name_scoreboard;
    logic [SEED_W-1:0] seed = '0;
    name_entry_t pending_names[$];
    int errors = 0;
    int requests = 0;
    int results = 0;
    int walked = 0;
    int longest_walk = 0;

    // One keyed pass over the 12-bit space
    function logic [VALUE_W-1:0] permute12(logic [VALUE_W-1:0] start);
      logic [VALUE_W-1:0] v;
      logic [VALUE_W-1:0] keys [ROUNDS];
      keys[0] = seed[11:0];
      keys[1] = seed[19:8];
      keys[2] = seed[27:16];
      keys[3] = {4'h0, seed[31:24]};
      v = start;
      for (int r = 0; r < ROUNDS; r++) begin
        v = v ^ (v >> XS_SHIFT);
        v = v ^ keys[r];
        v = v * MIX_MUL[r];
      end
      v = v ^ (v >> XS_SHIFT);
      return v;
    endfunction

    // Cycle-walk into the domain, then split into adjective and noun
    function name_entry_t predict_name(logic [VALUE_W-1:0] seq, output int passes);
      name_entry_t e;
      logic [VALUE_W-1:0] v;
      bit found;
      v = seq;
      found = 0;
      passes = 0;
      while (!found && passes < WALK_LIMIT) begin
        v = permute12(v);
        passes++;
        if (v < NAME_DOMAIN) found = 1;
      end
      if (found) begin
        e.value = v;
        e.adj   = ADJ_W'(v % ADJ_COUNT);
        e.noun  = NOUN_W'(v / ADJ_COUNT);
      end else begin
        e.value = '0;
        e.adj   = '0;
        e.noun  = '0;
      end
      return e;
    endfunction

    function void note_request(logic [VALUE_W-1:0] seq);
      int passes;
      pending_names.push_back(predict_name(seq, passes));
      requests++;
      if (passes > 1) walked++;
      if (passes > longest_walk) longest_walk = passes;
    endfunction

    function void check_result(logic [VALUE_W-1:0] value, logic [ADJ_W-1:0] adj,
                               logic [NOUN_W-1:0] noun);
      name_entry_t e;
      if (pending_names.size() == 0) begin
        $error("result with no request pending: permuted_value %0d", value);
        errors++;
        return;
      end
      e = pending_names.pop_front();
      results++;
      if (value !== e.value) begin
        $error("permuted_value: expected %0d, got %0d", e.value, value);
        errors++;
      end
      if (adj !== e.adj) begin
        $error("adjective_index: expected %0d, got %0d", e.adj, adj);
        errors++;
      end
      if (noun !== e.noun) begin
        $error("noun_index: expected %0d, got %0d", e.noun, noun);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_names.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   quiet_cycles = 0;
  name_scoreboard names;

  pni_in_if  in_ch();
  pni_out_if out_ch();
  pni_cfg_if cfg_ch();

  permuted_name_index dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #1 clk = ~clk;

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: seed writes, results, then new requests
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) names.seed = cfg_ch.seed;
      if (out_ch.valid && out_ch.ready)
        names.check_result(out_ch.permuted_value, out_ch.adjective_index,
                           out_ch.noun_index);
      if (in_ch.valid && in_ch.ready) names.note_request(in_ch.sequence_number);
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("permuted_name_index regression: fail");
      $finish;
    end
  end

  task automatic set_idling(idling_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 66;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct = 66;
      end
      default: begin
        send_idle_pct = 10;
        recv_stall_pct = 10;
      end
    endcase
  endtask

  // Valid stays high into the next request unless the sender idles
  task automatic push_request(logic [VALUE_W-1:0] seq);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sequence_number <= seq;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stop sending and let every pending name come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (names.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(logic [SEED_W-1:0] s);
    cfg_ch.valid <= 1'b1;
    cfg_ch.seed <= s;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [SEED_W-1:0]  seeds [NUM_PHASES];
    logic [VALUE_W-1:0] directed [$];
    logic [VALUE_W-1:0] walk_inputs [$];
    logic [VALUE_W-1:0] seq;
    int r;

    names = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.sequence_number = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.seed = '0;
    out_ch.ready = 1'b0;

    seeds[0] = 32'h0000_0000;
    seeds[1] = 32'hffff_ffff;
    seeds[2] = 32'h0000_0001;
    seeds[3] = 32'h8000_0000;
    seeds[4] = $urandom;
    seeds[5] = 32'h00ff_ff00;
    seeds[6] = $urandom;
    seeds[7] = $urandom;

    // Field extremes, single bits and alternating patterns
    directed = {12'd0, 12'd4027, 12'd1, 12'd4026, 12'd2048, 12'd1024, 12'd512,
                12'd256, 12'd128, 12'd64, 12'd32, 12'd16, 12'd8, 12'd4, 12'd2,
                12'd2730, 12'd1365, 12'd3840, 12'd255};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_seed(seeds[p]);

      // Requests whose first pass leaves the domain and must walk again
      walk_inputs.delete();
      for (int x = 0; x < NAME_DOMAIN; x++)
        if (names.permute12(VALUE_W'(x)) >= NAME_DOMAIN) walk_inputs.push_back(VALUE_W'(x));

      set_idling(idling_t'(p % 4));

      if (p == 0) begin
        foreach (directed[i]) push_request(directed[i]);
        for (int i = 0; i < 4 && i < walk_inputs.size(); i++) push_request(walk_inputs[i]);
      end

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Hold off once mid-phase until the block has emptied
        if (p == 2 && i == ITEMS_PER_PHASE / 2) wait_drained();
        r = $urandom_range(99);
        if (r < 25 && walk_inputs.size() > 0)
          seq = walk_inputs[$urandom_range(walk_inputs.size() - 1)];
        else if (r < 28)
          seq = '0;
        else if (r < 31)
          seq = VALUE_W'(NAME_DOMAIN - 1);
        else
          seq = VALUE_W'($urandom_range(NAME_DOMAIN - 1));
        push_request(seq);
      end

      wait_drained();
    end

    set_idling(IDLE_NONE);
    wait_drained();

    $display("Ran %0d requests under %0d seeds, including all-zero and all-one, with %0s",
             names.requests, NUM_PHASES, "four idling patterns and a mid-run drain.");
    $display("%0d results checked; %0d requests needed extra walk passes (longest %0d).",
             names.results, names.walked, names.longest_walk);
    if (names.errors == 0 && names.outstanding() == 0) begin
      $display("permuted_name_index regression: pass");
    end else begin
      $display("permuted_name_index regression: fail");
    end
    $finish;
  end

endmodule

// File: permuted_name_index.f
design/pni_pkg.sv
design/pni_in_if.sv
design/pni_out_if.sv
design/pni_cfg_if.sv
design/pni_ctrl.sv
design/pni_dp.sv
design/permuted_name_index.sv
sim/testbench.sv
